>>> rtl/core/assert_macros.svh
// Assertion macros of the integer ALU, used by the queue (eia_fifo.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EIA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EIA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EIA_ASSERT(lbl, clk, rst, prop, msg)
`define EIA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/core/eia_pkg.sv
// Types and constants of the element-wise integer ALU.
package eia_pkg;

   localparam int DATA_W      = 32;
   localparam int OP_W        = 6;
   localparam int MULSHR_BITS = 8;

   typedef enum logic [OP_W-1:0] {
      OP_IGNORE = 6'd0, OP_PUT, OP_ADD, OP_SUB, OP_BUS, OP_MUL, OP_MULSHR,
      OP_DIV, OP_DIV_FLOOR, OP_DIV_SWAP, OP_DIV_FLOOR_SWAP,
      OP_MOD, OP_MOD_SWAP, OP_REM, OP_REM_SWAP,
      OP_GCD, OP_LCM, OP_OR, OP_XOR, OP_AND, OP_SHL, OP_SHR,
      OP_SC_AND, OP_SC_OR, OP_MIN, OP_MAX,
      OP_EQ, OP_NE, OP_GT, OP_LE, OP_LT, OP_GE, OP_CMP, OP_POW,
      OP_ABSDIFF, OP_SQDIFF, OP_AVG, OP_HYPOT, OP_SQRT
   } op_type;

   typedef enum logic [2:0] {
      CLS_SIMPLE, CLS_MUL, CLS_DIV, CLS_GCD, CLS_LCM, CLS_POW, CLS_HYPOT, CLS_SQRT
   } cls_type;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] operand_a;
      logic signed [DATA_W-1:0] operand_b;
      logic                     last_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result;
      logic                     last_out;
   } rsp_type;

   typedef struct packed {
      cls_type cls;
      req_type req;
   } entry_type;

endpackage

>>> rtl/core/elementwise_integer_alu.sv
// Top level of the element-wise integer ALU: front end, queue, execution sequencer.
//
//   channel   direction  handshake             beat
//   req_      in         req_valid/req_stall   req_type: op, operands, last mark
//   rsp_      out        rsp_valid/rsp_stall   rsp_type: result, last mark
//
// Per beat the sequencer computes logic, compare and add ops directly, runs multiplies
// on the multiplier, divide/modulo on a bit-serial divider (skipped for a zero divisor),
// gcd as a binary gcd loop, lcm as gcd, divide and multiply (skipped for a zero operand),
// power on the one shared 32x32 multiplier (a conditional multiply and a squaring per
// exponent bit), and square root and hypot at two radicand bits per cycle.
// Synchronous active-high reset clears the handshake, queue pointers and sequencer state only.
// A stalled result waits in the output register while the next beat is worked on.
module elementwise_integer_alu
   import eia_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic      push, pop, q_full, q_valid;
   entry_type push_data, pop_data;

   eia_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   eia_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (q_valid)
   );

   eia_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/eia_front.sv
// Front end: takes request beats and tags each with its execution class.
module eia_front
   import eia_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  logic      q_full,
   output logic      push,
   output entry_type push_data
);

   logic      v_ff, v_in;
   entry_type item_ff;
   logic      accept;

   function automatic cls_type classify(logic [OP_W-1:0] op);
      cls_type c;
      case (op_type'(op))
         OP_MUL, OP_MULSHR, OP_SQDIFF:                  c = CLS_MUL;
         OP_DIV, OP_DIV_FLOOR, OP_DIV_SWAP, OP_DIV_FLOOR_SWAP,
         OP_MOD, OP_MOD_SWAP, OP_REM, OP_REM_SWAP:      c = CLS_DIV;
         OP_GCD:                                        c = CLS_GCD;
         OP_LCM:                                        c = CLS_LCM;
         OP_POW:                                        c = CLS_POW;
         OP_HYPOT:                                      c = CLS_HYPOT;
         OP_SQRT:                                       c = CLS_SQRT;
         default:                                       c = CLS_SIMPLE;
      endcase
      return c;
   endfunction

   assign req_stall = v_ff & q_full;
   assign accept    = req_valid & ~req_stall;
   assign push      = v_ff & ~q_full;
   assign push_data = item_ff;
   assign v_in      = accept | (v_ff & q_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= '{cls: classify(req_data.op), req: req_data};
      end
   end

endmodule

>>> rtl/core/eia_fifo.sv
// Short queue between the front end and the execution sequencer.
`include "assert_macros.svh"
module eia_fifo
   import eia_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `EIA_ASSERT(a_no_overflow, clock, reset, push |-> !full, "push into a full queue")
   `EIA_ASSERT(a_no_underflow, clock, reset, pop |-> not_empty, "pop from an empty queue")
   `EIA_ASSERT(a_count_up, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1), "queue count lost a beat")
   `EIA_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> (count_ff == '0), "queue not empty after reset")

endmodule

>>> rtl/core/eia_exec.sv
// Execution sequencer: shared multiplier, divider, gcd and square root steps.
module eia_exec
   import eia_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  entry_type q_data,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   typedef enum logic [10:0] {
      ST_IDLE = 11'b00000000001,
      ST_MUL  = 11'b00000000010,
      ST_DIV  = 11'b00000000100,
      ST_DFIX = 11'b00000001000,
      ST_GCD  = 11'b00000010000,
      ST_POW  = 11'b00000100000,
      ST_HSQA = 11'b00001000000,
      ST_HSQB = 11'b00010000000,
      ST_HADD = 11'b00100000000,
      ST_SQRT = 11'b01000000000,
      ST_DONE = 11'b10000000000
   } state_type;

   state_type   state_ff, state_in;
   op_type      op_ff, op_in;
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic        last_ff, last_in;
   logic [31:0] res_ff, res_in;
   logic [31:0] mx_ff, mx_in, my_ff, my_in;
   logic [31:0] dq_ff, dq_in, dr_ff, dr_in, dm_ff, dm_in, dval_ff, dval_in;
   logic        nneg_ff, nneg_in, dneg_ff, dneg_in;
   logic [31:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [4:0]  gk_ff, gk_in;
   logic [31:0] pr_ff, pr_in, px_ff, px_in;
   logic [30:0] pe_ff, pe_in;
   logic        pph_ff, pph_in;
   logic [63:0] rad_ff, rad_in, sq_ff, sq_in;
   logic [31:0] rt_ff, rt_in;
   logic [33:0] rm_ff, rm_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        out_v_ff, out_v_in;
   rsp_type     out_ff, out_in;

   logic [31:0] mul_x, mul_y;
   logic [63:0] prod;
   logic [31:0] amag, bmag;

   logic [31:0] qa, qb, n_sel, d_sel, dif, g;
   logic        swap;
   logic [32:0] div_rs, div_trial;
   logic [31:0] tq, tr, fq, fm;
   logic [35:0] sq_rs, sq_trial;

   function automatic logic [31:0] mag(logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   function automatic logic [31:0] simple_alu(op_type op, logic [31:0] a, logic [31:0] b);
      logic signed [31:0] sa, sb;
      logic [31:0]        d, m, r;
      logic               big;
      sa  = a;
      sb  = b;
      big = b[31] | (|b[30:5]);
      d   = '0;
      m   = '0;
      case (op)
         OP_IGNORE:  r = a;
         OP_PUT:     r = b;
         OP_ADD:     r = a + b;
         OP_SUB:     r = a - b;
         OP_BUS:     r = b - a;
         OP_OR:      r = a | b;
         OP_XOR:     r = a ^ b;
         OP_AND:     r = a & b;
         OP_SHL:     r = big ? '0 : (a << b[4:0]);
         OP_SHR:     r = big ? {32{a[31]}} : 32'(sa >>> b[4:0]);
         OP_SC_AND:  r = (a != '0) ? b : '0;
         OP_SC_OR:   r = (a != '0) ? a : b;
         OP_MIN:     r = (sb < sa) ? b : a;
         OP_MAX:     r = (sa < sb) ? b : a;
         OP_EQ:      r = {31'd0, a == b};
         OP_NE:      r = {31'd0, a != b};
         OP_GT:      r = {31'd0, sb < sa};
         OP_LE:      r = {31'd0, !(sb < sa)};
         OP_LT:      r = {31'd0, sa < sb};
         OP_GE:      r = {31'd0, !(sa < sb)};
         OP_CMP:     r = (sa < sb) ? '1 : ((a == b) ? 32'd0 : 32'd1);
         OP_ABSDIFF: begin
            d = a - b;
            r = mag(d);
         end
         OP_AVG: begin
            // halve the magnitude so the result rounds toward zero
            d = a + b;
            m = mag(d) >> 1;
            r = d[31] ? (32'd0 - m) : m;
         end
         default:    r = '0;
      endcase
      return r;
   endfunction

   assign amag = mag(a_ff);
   assign bmag = mag(b_ff);
   assign qa   = q_data.req.operand_a;
   assign qb   = q_data.req.operand_b;

   always_comb begin
      case (state_ff)
         ST_POW: begin
            mul_x = pph_ff ? px_ff : pr_ff;
            mul_y = px_ff;
         end
         ST_HSQA: begin
            mul_x = amag;
            mul_y = amag;
         end
         ST_HSQB: begin
            mul_x = bmag;
            mul_y = bmag;
         end
         default: begin
            mul_x = mx_ff;
            mul_y = my_ff;
         end
      endcase
   end

   assign prod = 64'(mul_x) * 64'(mul_y);

   // divider step and sign fixup
   assign div_rs    = {dr_ff, dq_ff[31]};
   assign div_trial = div_rs - {1'b0, dm_ff};
   assign tq = (nneg_ff ^ dneg_ff) ? (32'd0 - dq_ff) : dq_ff;
   assign tr = nneg_ff ? (32'd0 - dr_ff) : dr_ff;
   assign fq = ((nneg_ff ^ dneg_ff) && dr_ff != '0) ? tq - 32'd1 : tq;
   assign fm = ((nneg_ff ^ dneg_ff) && dr_ff != '0) ? tr + dval_ff : tr;

   // square root step: two radicand bits per cycle
   assign sq_rs    = {rm_ff, rad_ff[63:62]};
   assign sq_trial = sq_rs - {2'b00, rt_ff, 2'b01};

   assign g = ((gx_ff == '0) ? gy_ff : gx_ff) << gk_ff;

   always_comb begin
      swap  = (q_data.req.op == OP_DIV_SWAP) || (q_data.req.op == OP_DIV_FLOOR_SWAP) ||
              (q_data.req.op == OP_MOD_SWAP) || (q_data.req.op == OP_REM_SWAP);
      n_sel = swap ? qb : qa;
      d_sel = swap ? qa : qb;
      dif   = qa - qb;
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      last_in  = last_ff;
      res_in   = res_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      dq_in    = dq_ff;
      dr_in    = dr_ff;
      dm_in    = dm_ff;
      dval_in  = dval_ff;
      nneg_in  = nneg_ff;
      dneg_in  = dneg_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      gk_in    = gk_ff;
      pr_in    = pr_ff;
      px_in    = px_ff;
      pe_in    = pe_ff;
      pph_in   = pph_ff;
      rad_in   = rad_ff;
      sq_in    = sq_ff;
      rt_in    = rt_ff;
      rm_in    = rm_ff;
      cnt_in   = cnt_ff;
      out_v_in = out_v_ff & rsp_stall;
      out_in   = out_ff;
      pop      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop     = 1'b1;
               op_in   = op_type'(q_data.req.op);
               a_in    = qa;
               b_in    = qb;
               last_in = q_data.req.last_in;
               case (q_data.cls)
                  CLS_MUL: begin
                     mx_in    = (q_data.req.op == OP_SQDIFF) ? dif : qa;
                     my_in    = (q_data.req.op == OP_SQDIFF) ? dif : qb;
                     state_in = ST_MUL;
                  end
                  CLS_DIV: begin
                     if (d_sel == '0) begin
                        res_in   = '0;
                        state_in = ST_DONE;
                     end else begin
                        dq_in    = mag(n_sel);
                        dr_in    = '0;
                        dm_in    = mag(d_sel);
                        dval_in  = d_sel;
                        nneg_in  = n_sel[31];
                        dneg_in  = d_sel[31];
                        cnt_in   = '1;
                        state_in = ST_DIV;
                     end
                  end
                  CLS_GCD, CLS_LCM: begin
                     if (q_data.cls == CLS_LCM && (qa == '0 || qb == '0)) begin
                        res_in   = '0;
                        state_in = ST_DONE;
                     end else begin
                        gx_in    = mag(qa);
                        gy_in    = mag(qb);
                        gk_in    = '0;
                        state_in = ST_GCD;
                     end
                  end
                  CLS_POW: begin
                     if (qb[31]) begin
                        if (qa == 32'd1) begin
                           res_in = 32'd1;
                        end else if (qa == '1) begin
                           res_in = qb[0] ? '1 : 32'd1;
                        end else begin
                           res_in = '0;
                        end
                        state_in = ST_DONE;
                     end else begin
                        pr_in    = 32'd1;
                        px_in    = qa;
                        pe_in    = qb[30:0];
                        pph_in   = 1'b0;
                        state_in = ST_POW;
                     end
                  end
                  CLS_HYPOT: begin
                     state_in = ST_HSQA;
                  end
                  CLS_SQRT: begin
                     if (qa[31]) begin
                        res_in   = '0;
                        state_in = ST_DONE;
                     end else begin
                        rad_in   = {32'd0, qa};
                        rt_in    = '0;
                        rm_in    = '0;
                        cnt_in   = '1;
                        state_in = ST_SQRT;
                     end
                  end
                  default: begin
                     res_in   = simple_alu(op_type'(q_data.req.op), qa, qb);
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_MUL: begin
            res_in   = (op_ff == OP_MULSHR) ? 32'($signed(prod[31:0]) >>> MULSHR_BITS)
                                            : prod[31:0];
            state_in = ST_DONE;
         end
         ST_DIV: begin
            if (!div_trial[32]) begin
               dr_in = div_trial[31:0];
               dq_in = {dq_ff[30:0], 1'b1};
            end else begin
               dr_in = div_rs[31:0];
               dq_in = {dq_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DFIX;
            end
         end
         ST_DFIX: begin
            case (op_ff)
               OP_LCM: begin
                  mx_in = dq_ff;
                  my_in = bmag;
               end
               OP_DIV, OP_DIV_SWAP:             res_in = tq;
               OP_DIV_FLOOR, OP_DIV_FLOOR_SWAP: res_in = fq;
               OP_MOD, OP_MOD_SWAP:             res_in = fm;
               default:                         res_in = tr;
            endcase
            state_in = (op_ff == OP_LCM) ? ST_MUL : ST_DONE;
         end
         ST_GCD: begin
            if (gx_ff == '0 || gy_ff == '0) begin
               if (op_ff == OP_LCM) begin
                  // lcm: divide |a| by the gcd, then multiply by |b|
                  dq_in    = amag;
                  dr_in    = '0;
                  dm_in    = g;
                  dval_in  = g;
                  nneg_in  = 1'b0;
                  dneg_in  = 1'b0;
                  cnt_in   = '1;
                  state_in = ST_DIV;
               end else begin
                  res_in   = g;
                  state_in = ST_DONE;
               end
            end else if (!gx_ff[0] && !gy_ff[0]) begin
               gx_in = gx_ff >> 1;
               gy_in = gy_ff >> 1;
               gk_in = gk_ff + 1'b1;
            end else if (!gx_ff[0]) begin
               gx_in = gx_ff >> 1;
            end else if (!gy_ff[0]) begin
               gy_in = gy_ff >> 1;
            end else if (gx_ff >= gy_ff) begin
               gx_in = (gx_ff - gy_ff) >> 1;
            end else begin
               gy_in = (gy_ff - gx_ff) >> 1;
            end
         end
         ST_POW: begin
            if (!pph_ff) begin
               if (pe_ff == '0) begin
                  res_in   = pr_ff;
                  state_in = ST_DONE;
               end else begin
                  if (pe_ff[0]) begin
                     pr_in = prod[31:0];
                  end
                  pph_in = 1'b1;
               end
            end else begin
               px_in  = prod[31:0];
               pe_in  = pe_ff >> 1;
               pph_in = 1'b0;
            end
         end
         ST_HSQA: begin
            rad_in   = prod;
            state_in = ST_HSQB;
         end
         ST_HSQB: begin
            sq_in    = prod;
            state_in = ST_HADD;
         end
         ST_HADD: begin
            rad_in   = rad_ff + sq_ff;
            rt_in    = '0;
            rm_in    = '0;
            cnt_in   = '1;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (!sq_trial[35]) begin
               rm_in = sq_trial[33:0];
               rt_in = {rt_ff[30:0], 1'b1};
            end else begin
               rm_in = sq_rs[33:0];
               rt_in = {rt_ff[30:0], 1'b0};
            end
            rad_in = rad_ff << 2;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               res_in   = rt_in;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the result until the output register is free
            if (!out_v_ff || !rsp_stall) begin
               out_in   = '{result: res_ff, last_out: last_ff};
               out_v_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      last_ff <= last_in;
      res_ff  <= res_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      dq_ff   <= dq_in;
      dr_ff   <= dr_in;
      dm_ff   <= dm_in;
      dval_ff <= dval_in;
      nneg_ff <= nneg_in;
      dneg_ff <= dneg_in;
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      gk_ff   <= gk_in;
      pr_ff   <= pr_in;
      px_ff   <= px_in;
      pe_ff   <= pe_in;
      pph_ff  <= pph_in;
      rad_ff  <= rad_in;
      sq_ff   <= sq_in;
      rt_ff   <= rt_in;
      rm_ff   <= rm_in;
      cnt_ff  <= cnt_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

>>> test/tb_elementwise_integer_alu.sv
// Self-checking testbench for elementwise_integer_alu: directed table, then random beats.
module tb_elementwise_integer_alu;
   import eia_pkg::*;

   localparam int N_RANDOM    = 850;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 160;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type     beat_q[$];
   bit          typed_q[$];
   logic [31:0] typed_val_q[$];
   rsp_type     expected_rsp_q[$];

   int  send_idx = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  rsp_seen = 0;
   int  cycles = 0;
   int  errors = 0;
   bit  long_hold_done = 0;

   elementwise_integer_alu u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   function automatic longint unsigned mag_gcd(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic logic [63:0] floor_root(logic [127:0] s);
      logic [63:0] r, c;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         c = r | (64'd1 << i);
         if ({64'd0, c} * {64'd0, c} <= s) r = c;
      end
      return r;
   endfunction

   function automatic logic [31:0] alu_result(logic [5:0] op, logic signed [31:0] a32,
                                              logic signed [31:0] b32);
      longint          a, b, q, r;
      longint unsigned ma, mb, g, px, pr, e;
      logic [31:0]     w;
      logic signed [31:0] d;
      a  = a32;
      b  = b32;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      case (op)
         OP_IGNORE: return a32;
         OP_PUT:    return b32;
         OP_ADD:    return a32 + b32;
         OP_SUB:    return a32 - b32;
         OP_BUS:    return b32 - a32;
         OP_MUL:    return a32 * b32;
         OP_MULSHR: begin
            w = a32 * b32;
            return $signed(w) >>> MULSHR_BITS;
         end
         OP_DIV:       return (b == 0) ? 32'd0 : 32'(a / b);
         OP_DIV_SWAP:  return (a == 0) ? 32'd0 : 32'(b / a);
         OP_REM:       return (b == 0) ? 32'd0 : 32'(a % b);
         OP_REM_SWAP:  return (a == 0) ? 32'd0 : 32'(b % a);
         OP_DIV_FLOOR, OP_DIV_FLOOR_SWAP: begin
            if (op == OP_DIV_FLOOR_SWAP) begin
               q = a; a = b; b = q;
            end
            if (b == 0) return 32'd0;
            q = a / b;
            if (((a < 0) != (b < 0)) && (a % b != 0)) q = q - 1;
            return 32'(q);
         end
         OP_MOD, OP_MOD_SWAP: begin
            if (op == OP_MOD_SWAP) begin
               q = a; a = b; b = q;
            end
            if (b == 0) return 32'd0;
            r = a % b;
            if (r != 0 && ((r < 0) != (b < 0))) r = r + b;
            return 32'(r);
         end
         OP_GCD: return 32'(mag_gcd(ma, mb));
         OP_LCM: begin
            if (a == 0 || b == 0) return 32'd0;
            g = mag_gcd(ma, mb);
            return 32'((ma / g) * mb);
         end
         OP_OR:  return a32 | b32;
         OP_XOR: return a32 ^ b32;
         OP_AND: return a32 & b32;
         OP_SHL: return (b < 0 || b >= DATA_W) ? 32'd0 : 32'(a32 << b);
         OP_SHR: return (b < 0 || b >= DATA_W) ? {32{a32[31]}} : 32'(a32 >>> b);
         OP_SC_AND: return (a32 != 0) ? b32 : 32'd0;
         OP_SC_OR:  return (a32 != 0) ? a32 : b32;
         OP_MIN: return (b32 < a32) ? b32 : a32;
         OP_MAX: return (a32 < b32) ? b32 : a32;
         OP_EQ:  return 32'(a32 == b32);
         OP_NE:  return 32'(a32 != b32);
         OP_GT:  return 32'(a32 > b32);
         OP_LE:  return 32'(a32 <= b32);
         OP_LT:  return 32'(a32 < b32);
         OP_GE:  return 32'(a32 >= b32);
         OP_CMP: return (a32 < b32) ? 32'hFFFF_FFFF : ((a32 == b32) ? 32'd0 : 32'd1);
         OP_POW: begin
            if (b < 0) begin
               if (a == 1) return 32'd1;
               if (a == -1) return b32[0] ? 32'hFFFF_FFFF : 32'd1;
               return 32'd0;
            end
            pr = 1;
            px = a;
            e  = b;
            while (e != 0) begin
               if (e[0]) pr = pr * px;
               px = px * px;
               e  = e >> 1;
            end
            return 32'(pr);
         end
         OP_ABSDIFF: begin
            d = a32 - b32;
            return (d < 0) ? -d : d;
         end
         OP_SQDIFF: begin
            d = a32 - b32;
            return d * d;
         end
         OP_AVG: begin
            d = a32 + b32;
            return d / 2;
         end
         OP_HYPOT: return 32'(floor_root({64'd0, ma} * {64'd0, ma} + {64'd0, mb} * {64'd0, mb}));
         OP_SQRT:  return (a < 0) ? 32'd0 : 32'(floor_root({96'd0, a32}));
         default:  return 32'd0;
      endcase
   endfunction

   task automatic add_row(logic [5:0] op, logic [31:0] a, logic [31:0] b,
                          bit typed, logic [31:0] val);
      req_type t;
      t.op        = op;
      t.operand_a = a;
      t.operand_b = b;
      t.last_in   = beat_q.size() % 3 == 2;
      beat_q.push_back(t);
      typed_q.push_back(typed);
      typed_val_q.push_back(val);
   endtask

   function automatic logic [31:0] pick_operand();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return (r < 5) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (r < 15) return (r < 12) ? 32'hFFFF_FFFF : 32'd0;
      if (r < 55) return 32'($signed($urandom_range(0, 80)) - 40);
      if (r < 70) return 32'($urandom_range(0, 65535)) - 32'd32768;
      return $urandom();
   endfunction

   // sender: offer beats, hold payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back('{
               result:   typed_q[send_idx] ? typed_val_q[send_idx]
                         : alu_result(req_data.op, req_data.operand_a, req_data.operand_b),
               last_out: req_data.last_in});
            send_idx++;
            if ((send_idx / 64) % 4 == 1) send_gap = 0;
            else if ($urandom_range(0, 99) < 60) send_gap = 0;
            else if ($urandom_range(0, 9) < 9) send_gap = $urandom_range(1, 3);
            else send_gap = $urandom_range(10, 40);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (send_idx + (req_valid && !req_stall ? 0 : 0) < beat_q.size()
                         && !(req_valid && !req_stall && send_idx >= beat_q.size())) begin
               req_valid <= 1'b1;
               req_data  <= beat_q[send_idx];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stall bursts, one long hold-off to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!long_hold_done && rsp_seen >= 200) begin
            long_hold_done = 1;
            stall_left = 400;
            rsp_stall <= 1'b1;
         end else if ((rsp_seen / 64) % 4 == 2 || $urandom_range(0, 99) < 70) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2)
                                                    : $urandom_range(9, 39);
            rsp_stall <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected beat result=%h last_out=%b", $time,
                     rsp_data.result, rsp_data.last_out);
            errors++;
         end else begin
            if (rsp_data.result !== expected_rsp_q[0].result) begin
               $display("%0t: result expected %h actual %h", $time,
                        expected_rsp_q[0].result, rsp_data.result);
               errors++;
            end
            if (rsp_data.last_out !== expected_rsp_q[0].last_out) begin
               $display("%0t: last_out expected %b actual %b", $time,
                        expected_rsp_q[0].last_out, rsp_data.last_out);
               errors++;
            end
            void'(expected_rsp_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[elementwise_integer_alu] ERROR");
         $finish;
      end
   end

   initial begin
      req_type t;
      int r;
      add_row(OP_ADD, 32'h7FFF_FFFF, 32'd1, 1, 32'h8000_0000);
      add_row(OP_DIV, 32'd5, 32'd0, 1, 32'd0);
      add_row(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h8000_0000);
      add_row(OP_MOD, 32'h8000_0000, 32'hFFFF_FFFF, 1, 32'd0);
      add_row(OP_REM_SWAP, 32'd0, 32'd7, 1, 32'd0);
      add_row(OP_GCD, 32'd0, 32'd0, 1, 32'd0);
      add_row(OP_LCM, 32'd0, 32'd5, 1, 32'd0);
      add_row(OP_SHL, 32'd1, 32'd32, 1, 32'd0);
      add_row(OP_SHL, 32'd1, 32'hFFFF_FFFF, 1, 32'd0);
      add_row(OP_SHR, 32'h8000_0000, 32'd40, 1, 32'hFFFF_FFFF);
      add_row(OP_POW, 32'd0, 32'd0, 1, 32'd1);
      add_row(OP_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 1, 32'hFFFF_FFFF);
      add_row(OP_POW, 32'd2, 32'hFFFF_FFFF, 1, 32'd0);
      add_row(OP_ABSDIFF, 32'h8000_0000, 32'd0, 1, 32'h8000_0000);
      add_row(OP_SQRT, 32'hFFFF_FFFC, 32'd0, 1, 32'd0);
      add_row(6'd63, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'd0);
      add_row(OP_EQ, 32'd3, 32'd3, 1, 32'd1);
      add_row(OP_HYPOT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'd0);
      add_row(OP_HYPOT, 32'h8000_0000, 32'h8000_0000, 0, 32'd0);
      add_row(OP_MULSHR, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'd0);
      add_row(OP_AVG, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'd0);
      add_row(OP_DIV_FLOOR, 32'hFFFF_FFF9, 32'd2, 0, 32'd0);
      add_row(OP_MOD_SWAP, 32'd3, 32'hFFFF_FFF9, 0, 32'd0);
      add_row(OP_SQRT, 32'h7FFF_FFFF, 32'd0, 0, 32'd0);
      add_row(OP_LCM, 32'h8000_0000, 32'd3, 0, 32'd0);
      for (int i = 0; i < N_RANDOM; i++) begin
         r = $urandom_range(0, 99);
         t.op        = (r < 95) ? 6'($urandom_range(0, 38)) : 6'($urandom_range(39, 63));
         t.operand_a = pick_operand();
         t.operand_b = pick_operand();
         if ((t.op == OP_SHL || t.op == OP_SHR || t.op == OP_POW) && $urandom_range(0, 3) != 0)
            t.operand_b = 32'($signed($urandom_range(0, 42)) - 3);
         t.last_in   = $urandom_range(0, 1);
         beat_q.push_back(t);
         typed_q.push_back(0);
         typed_val_q.push_back(32'd0);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (send_idx < beat_q.size() || expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && expected_rsp_q.size() == 0) begin
         $display("[elementwise_integer_alu] OK");
      end else begin
         $display("[elementwise_integer_alu] ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/eia_pkg.sv
rtl/core/eia_front.sv
rtl/core/eia_fifo.sv
rtl/core/eia_exec.sv
rtl/core/elementwise_integer_alu.sv
test/tb_elementwise_integer_alu.sv
